/* rtl/core/fastcgi_record_deframer_macros.svh */
// Assertion macros for the FastCGI record deframer.
// No dependencies; included by files that carry concurrent checks.
`ifndef FASTCGI_RECORD_DEFRAMER_MACROS_SVH
`define FASTCGI_RECORD_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define FRD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define FRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRD_ASSERT(lbl, clk, rst, prop, msg)
`define FRD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/fcgi_dfr_pkg.sv */
// Types and constants for the FastCGI record deframer.
// No dependencies.
`default_nettype none

package fcgi_dfr_pkg;

  // Position in the record: eight header bytes, then content, then padding.
  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_TYPE     = 4'd1,
    PH_ID_HI    = 4'd2,
    PH_ID_LO    = 4'd3,
    PH_LEN_HI   = 4'd4,
    PH_LEN_LO   = 4'd5,
    PH_PAD_LEN  = 4'd6,
    PH_RESERVED = 4'd7,
    PH_CONTENT  = 4'd8,
    PH_PADDING  = 4'd9
  } phase_t;

  // Record type codes
  localparam logic [7:0] TYPE_END_REQUEST = 8'd3;
  localparam logic [7:0] TYPE_STDOUT      = 8'd6;
  localparam logic [7:0] TYPE_STDERR      = 8'd7;

  // Result kind codes
  localparam logic [1:0] KIND_STDOUT      = 2'd0;
  localparam logic [1:0] KIND_END_REQUEST = 2'd1;
  localparam logic [1:0] KIND_STDERR      = 2'd2;

endpackage

`default_nettype wire

/* rtl/core/fastcgi_record_deframer.sv */
// FastCGI response deframer: one byte per item, STDOUT content and end events out.
// Each result is registered from the byte that causes it and is valid in the next cycle.
// Throughput: one byte per cycle; in_ready drops only while a result is held.
// The single output register is the only buffering between the two sides.
// Reset (rst, synchronous): expects a version byte, clears the end flag and
// drops any held result.
// Uses fcgi_dfr_pkg and fastcgi_record_deframer_macros.svh.
`default_nettype none

`include "fastcgi_record_deframer_macros.svh"

module fastcgi_record_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       kind,
  output logic [15:0]      record_request_id,
  output logic             last_of_record
);

  fcgi_dfr_pkg::phase_t phase, phase_next;
  logic [7:0]  record_type, record_type_next;
  logic [15:0] rec_id, rec_id_next;
  logic [15:0] content_remaining, content_remaining_next;
  logic [7:0]  padding_remaining, padding_remaining_next;
  logic        finished;

  logic        accept;
  logic [15:0] content_dec;
  logic [7:0]  padding_dec;
  logic        is_stdout;
  logic        is_end_type;
  logic        complete;
  logic        emit_content;
  logic        emit_end;
  logic        res_valid;
  logic [1:0]  res_kind;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign content_dec = (content_remaining != 16'd0) ? content_remaining - 16'd1
                                                    : content_remaining;
  assign padding_dec = (padding_remaining != 8'd0) ? padding_remaining - 8'd1
                                                   : padding_remaining;
  assign is_stdout   = (record_type == fcgi_dfr_pkg::TYPE_STDOUT);
  assign is_end_type = (record_type == fcgi_dfr_pkg::TYPE_END_REQUEST) ||
                       (record_type == fcgi_dfr_pkg::TYPE_STDERR);

  // Record consumed by this byte, except STDOUT content; STDOUT never ends the stream
  always_comb begin
    complete = 1'b0;
    unique case (phase)
      fcgi_dfr_pkg::PH_RESERVED:
        complete = (content_remaining == 16'd0) && (padding_remaining == 8'd0);
      fcgi_dfr_pkg::PH_CONTENT:
        complete = (content_dec == 16'd0) && (padding_remaining == 8'd0) && !is_stdout;
      fcgi_dfr_pkg::PH_PADDING:
        complete = (padding_dec == 8'd0);
      default:
        complete = 1'b0;
    endcase
  end

  assign emit_content = (phase == fcgi_dfr_pkg::PH_CONTENT) && is_stdout;
  assign emit_end     = complete && is_end_type;
  assign res_valid    = !finished && (emit_content || emit_end);
  assign res_kind     = emit_content ? fcgi_dfr_pkg::KIND_STDOUT :
                        (record_type == fcgi_dfr_pkg::TYPE_END_REQUEST)
                          ? fcgi_dfr_pkg::KIND_END_REQUEST : fcgi_dfr_pkg::KIND_STDERR;

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      fcgi_dfr_pkg::PH_TYPE:    phase_next = fcgi_dfr_pkg::PH_ID_HI;
      fcgi_dfr_pkg::PH_ID_HI:   phase_next = fcgi_dfr_pkg::PH_ID_LO;
      fcgi_dfr_pkg::PH_ID_LO:   phase_next = fcgi_dfr_pkg::PH_LEN_HI;
      fcgi_dfr_pkg::PH_LEN_HI:  phase_next = fcgi_dfr_pkg::PH_LEN_LO;
      fcgi_dfr_pkg::PH_LEN_LO:  phase_next = fcgi_dfr_pkg::PH_PAD_LEN;
      fcgi_dfr_pkg::PH_PAD_LEN: phase_next = fcgi_dfr_pkg::PH_RESERVED;
      fcgi_dfr_pkg::PH_RESERVED: begin
        priority if (content_remaining != 16'd0) phase_next = fcgi_dfr_pkg::PH_CONTENT;
        else if (padding_remaining != 8'd0)      phase_next = fcgi_dfr_pkg::PH_PADDING;
        else                                     phase_next = fcgi_dfr_pkg::PH_VERSION;
      end
      fcgi_dfr_pkg::PH_CONTENT: begin
        priority if (content_dec != 16'd0)  phase_next = fcgi_dfr_pkg::PH_CONTENT;
        else if (padding_remaining != 8'd0) phase_next = fcgi_dfr_pkg::PH_PADDING;
        else                                phase_next = fcgi_dfr_pkg::PH_VERSION;
      end
      fcgi_dfr_pkg::PH_PADDING:
        phase_next = (padding_dec == 8'd0) ? fcgi_dfr_pkg::PH_VERSION
                                           : fcgi_dfr_pkg::PH_PADDING;
      default: phase_next = fcgi_dfr_pkg::PH_TYPE;  // version byte, not checked
    endcase
  end

  // Header fields and counters
  always_comb begin
    record_type_next       = record_type;
    rec_id_next            = rec_id;
    content_remaining_next = content_remaining;
    padding_remaining_next = padding_remaining;
    unique case (phase)
      fcgi_dfr_pkg::PH_TYPE:    record_type_next = in_byte;
      fcgi_dfr_pkg::PH_ID_HI:   rec_id_next = {in_byte, 8'd0};
      fcgi_dfr_pkg::PH_ID_LO:   rec_id_next = {rec_id[15:8], in_byte};
      fcgi_dfr_pkg::PH_LEN_HI:  content_remaining_next = {in_byte, 8'd0};
      fcgi_dfr_pkg::PH_LEN_LO:  content_remaining_next = {content_remaining[15:8], in_byte};
      fcgi_dfr_pkg::PH_PAD_LEN: padding_remaining_next = in_byte;
      fcgi_dfr_pkg::PH_CONTENT: content_remaining_next = content_dec;
      fcgi_dfr_pkg::PH_PADDING: padding_remaining_next = padding_dec;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= fcgi_dfr_pkg::PH_VERSION;
      record_type       <= 8'd0;
      rec_id            <= 16'd0;
      content_remaining <= 16'd0;
      padding_remaining <= 8'd0;
      finished          <= 1'b0;
    end else if (accept && !finished) begin
      phase             <= phase_next;
      record_type       <= record_type_next;
      rec_id            <= rec_id_next;
      content_remaining <= content_remaining_next;
      padding_remaining <= padding_remaining_next;
      finished          <= emit_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; end events carry a zero byte and no last mark
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_byte          <= emit_content ? in_byte : 8'd0;
      kind              <= res_kind;
      record_request_id <= rec_id;
      last_of_record    <= emit_content && (content_remaining <= 16'd1);
    end
  end

  `FRD_ASSERT(a_finished_sticky, clk, rst, finished |=> finished, "end flag cleared outside reset")
  `FRD_ASSERT(a_no_result_after_end, clk, rst, accept && finished |=> !out_valid, "result after end event")
  `FRD_ASSERT(a_end_sets_flag, clk, rst, out_valid && kind != fcgi_dfr_pkg::KIND_STDOUT |-> finished, "end event without end flag")
  `FRD_ASSERT(a_end_payload, clk, rst, out_valid && kind != fcgi_dfr_pkg::KIND_STDOUT |-> out_byte == 8'd0 && !last_of_record, "end event with content payload")
  `FRD_ASSERT(a_content_nonzero, clk, rst, phase == fcgi_dfr_pkg::PH_CONTENT |-> content_remaining != 16'd0, "content phase with no bytes left")

endmodule

`default_nettype wire
